// ----- rtl/hbwd_pkg.sv -----
`default_nettype none

package hbwd_pkg;

   // watchdog states, also used as the entered code (init means none)
   typedef enum logic [2:0] {
      ST_INIT     = 3'd0,
      ST_NORMAL   = 3'd1,
      ST_ALARM    = 3'd2,
      ST_FAULT    = 3'd3,
      ST_RECOVERY = 3'd4
   } wd_state_type;

   // request operation codes
   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_SAMPLE  = 2'd1,
      OP_DISABLE = 2'd2,
      OP_ENABLE  = 2'd3
   } op_type;

   // register map
   localparam int CsrIndexWidth = 8;
   localparam logic [CsrIndexWidth-1:0] CSR_ALARM_TIMEOUT    = 8'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_FAULT_TIMEOUT    = 8'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_RECOVERY_TIMEOUT = 8'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_RECOVER_HOLD     = 8'd3;

   localparam logic [15:0] ALARM_TIMEOUT_RESET    = 16'd10;
   localparam logic [15:0] FAULT_TIMEOUT_RESET    = 16'd20;
   localparam logic [15:0] RECOVERY_TIMEOUT_RESET = 16'd20;
   localparam logic [15:0] RECOVER_HOLD_RESET     = 16'd10;

   localparam logic [1:0] CHANGE_COUNT_MAX = 2'd2;

   typedef struct packed {
      logic [15:0] alarm_timeout;
      logic [15:0] fault_timeout;
      logic [15:0] recovery_timeout;
      logic [15:0] recover_hold;
   } cfg_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] beat_value;
   } item_type;

   typedef struct packed {
      wd_state_type wd_state;
      logic         is_enabled;
      wd_state_type entered;
      logic [31:0]  worst_fault_recovery;
      logic [31:0]  worst_alarm_recovery;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/hbwd_csr.sv -----
`default_nettype none

module hbwd_csr
   import hbwd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [15:0]              csr_wdata,
   output cfg_type                       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register write decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ALARM_TIMEOUT:    cfg_in.alarm_timeout    = csr_wdata;
            CSR_FAULT_TIMEOUT:    cfg_in.fault_timeout    = csr_wdata;
            CSR_RECOVERY_TIMEOUT: cfg_in.recovery_timeout = csr_wdata;
            CSR_RECOVER_HOLD:     cfg_in.recover_hold     = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alarm_timeout    <= ALARM_TIMEOUT_RESET;
         cfg_ff.fault_timeout    <= FAULT_TIMEOUT_RESET;
         cfg_ff.recovery_timeout <= RECOVERY_TIMEOUT_RESET;
         cfg_ff.recover_hold     <= RECOVER_HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/hbwd_in_stage.sv -----
`default_nettype none

module hbwd_in_stage
   import hbwd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_op,
   input  wire logic [15:0] req_beat_value,
   input  wire logic        advance,
   output logic             item_valid,
   output item_type         item
);

   logic     item_valid_ff;
   item_type item_ff;
   item_type item_in;

   // hold the request while the held item cannot move on
   assign req_stall  = item_valid_ff && !advance;
   assign item_valid = item_valid_ff;
   assign item       = item_ff;

   always_comb begin
      item_in.op         = op_type'(req_op);
      item_in.beat_value = req_beat_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/hbwd_engine.sv -----
`default_nettype none

module hbwd_engine
   import hbwd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       item_valid,
   input  wire item_type   item,
   input  wire logic       advance,
   input  wire cfg_type    cfg,
   output result_type      result
);

   wd_state_type state_ff, state_in;
   logic         enabled_ff, enabled_in;
   logic [31:0]  tick_ff, tick_in;
   logic [15:0]  last_beat_ff, last_beat_in;
   logic [31:0]  change_time_ff, change_time_in;
   logic [31:0]  prior_change_ff, prior_change_in;
   logic         change_seen_ff, change_seen_in;
   logic [1:0]   change_count_ff, change_count_in;
   logic [31:0]  alarm_time_ff, alarm_time_in;
   logic [31:0]  fault_time_ff, fault_time_in;
   logic [31:0]  rec_start_ff, rec_start_in;
   logic [31:0]  max_fault_ff, max_fault_in;
   logic [31:0]  max_alarm_ff, max_alarm_in;

   logic         fire;
   logic [31:0]  tick_next;
   logic [31:0]  since;
   logic [31:0]  between;
   logic [31:0]  in_rec;
   logic [31:0]  fault_span;
   logic [31:0]  alarm_span;
   logic         fresh;
   logic         beat_changed;

   assign fire         = item_valid && advance;
   assign tick_next    = tick_ff + 32'd1;
   assign since        = tick_next - change_time_ff;
   assign between      = change_time_ff - prior_change_ff;
   assign in_rec       = tick_next - rec_start_ff;
   assign fault_span   = tick_next - fault_time_ff;
   assign alarm_span   = tick_next - alarm_time_ff;
   assign beat_changed = item.beat_value != last_beat_ff;

   // recent enough changes to allow recovery
   assign fresh = (since <= {16'd0, cfg.alarm_timeout}) &&
                  (between <= {16'd0, cfg.alarm_timeout}) &&
                  (change_count_ff == CHANGE_COUNT_MAX);

   // next state
   always_comb begin
      state_in = state_ff;
      case (item.op)
         OP_TICK: begin
            if (state_ff == ST_INIT) begin
               if (change_seen_ff) begin
                  state_in = ST_NORMAL;
               end
            end else if (enabled_ff) begin
               if (state_ff == ST_NORMAL && since >= {16'd0, cfg.alarm_timeout}) begin
                  state_in = ST_ALARM;
               end else if ((state_ff == ST_ALARM &&
                             since >= {16'd0, cfg.fault_timeout}) ||
                            (state_ff == ST_RECOVERY &&
                             since >= {16'd0, cfg.recovery_timeout})) begin
                  state_in = ST_FAULT;
               end else if ((state_ff == ST_FAULT || state_ff == ST_ALARM) && fresh) begin
                  state_in = ST_RECOVERY;
               end else if (state_ff == ST_RECOVERY &&
                            in_rec >= {16'd0, cfg.recover_hold}) begin
                  state_in = ST_NORMAL;
               end
            end
         end
         OP_DISABLE: begin
            if (state_ff != ST_INIT) begin
               state_in = ST_NORMAL;
            end
         end
         default: state_in = state_ff;
      endcase
   end

   // timestamps, change tracking and worst-case recovery times
   always_comb begin
      enabled_in      = enabled_ff;
      tick_in         = tick_ff;
      last_beat_in    = last_beat_ff;
      change_time_in  = change_time_ff;
      prior_change_in = prior_change_ff;
      change_seen_in  = change_seen_ff;
      change_count_in = change_count_ff;
      alarm_time_in   = alarm_time_ff;
      fault_time_in   = fault_time_ff;
      rec_start_in    = rec_start_ff;
      max_fault_in    = max_fault_ff;
      max_alarm_in    = max_alarm_ff;
      case (item.op)
         OP_TICK: begin
            tick_in = tick_next;
            if (state_in != state_ff) begin
               case (state_in)
                  ST_ALARM: alarm_time_in = tick_next;
                  ST_FAULT: fault_time_in = tick_next;
                  ST_RECOVERY: begin
                     rec_start_in = tick_next;
                     if (state_ff == ST_FAULT) begin
                        if (fault_span > max_fault_ff) begin
                           max_fault_in = fault_span;
                        end
                     end else if (alarm_span > max_alarm_ff) begin
                        max_alarm_in = alarm_span;
                     end
                  end
                  default: rec_start_in = rec_start_ff;
               endcase
            end
         end
         OP_SAMPLE: begin
            if (beat_changed) begin
               if (change_count_ff != CHANGE_COUNT_MAX) begin
                  change_count_in = change_count_ff + 2'd1;
               end
               prior_change_in = change_time_ff;
               change_time_in  = tick_ff;
               change_seen_in  = 1'b1;
               last_beat_in    = item.beat_value;
            end
         end
         OP_DISABLE: begin
            enabled_in      = 1'b0;
            alarm_time_in   = '0;
            fault_time_in   = '0;
            rec_start_in    = '0;
            last_beat_in    = '0;
            change_time_in  = '0;
            prior_change_in = '0;
            change_seen_in  = 1'b0;
         end
         OP_ENABLE: begin
            enabled_in = 1'b1;
         end
         default: enabled_in = enabled_ff;
      endcase
   end

   // result of this transaction, taken from the updated state
   always_comb begin
      result.wd_state             = state_in;
      result.is_enabled           = enabled_in;
      result.entered              = (state_in != state_ff) ? state_in : ST_INIT;
      result.worst_fault_recovery = max_fault_in;
      result.worst_alarm_recovery = max_alarm_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_INIT;
         enabled_ff      <= 1'b1;
         tick_ff         <= '0;
         last_beat_ff    <= '0;
         change_time_ff  <= '0;
         prior_change_ff <= '0;
         change_seen_ff  <= 1'b0;
         change_count_ff <= '0;
         alarm_time_ff   <= '0;
         fault_time_ff   <= '0;
         rec_start_ff    <= '0;
         max_fault_ff    <= '0;
         max_alarm_ff    <= '0;
      end else if (fire) begin
         state_ff        <= state_in;
         enabled_ff      <= enabled_in;
         tick_ff         <= tick_in;
         last_beat_ff    <= last_beat_in;
         change_time_ff  <= change_time_in;
         prior_change_ff <= prior_change_in;
         change_seen_ff  <= change_seen_in;
         change_count_ff <= change_count_in;
         alarm_time_ff   <= alarm_time_in;
         fault_time_ff   <= fault_time_in;
         rec_start_ff    <= rec_start_in;
         max_fault_ff    <= max_fault_in;
         max_alarm_ff    <= max_alarm_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/hbwd_out_stage.sv -----
`default_nettype none

module hbwd_out_stage
   import hbwd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       item_valid,
   input  wire result_type result,
   output logic            advance,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output result_type      rsp_result
);

   logic       rsp_valid_ff;
   result_type rsp_result_ff;

   // the result register can load when empty or being taken
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && item_valid) begin
         rsp_result_ff <= result;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/heartbeat_watchdog_fsm_core.sv -----
// Heartbeat watchdog core.
// Request channel (req_valid / req_stall): one transaction carries an op
// (tick, heartbeat sample, disable, enable) and a 16-bit beat value.
// Response channel (rsp_valid / rsp_stall): exactly one transaction per
// request, in order, with the watchdog state, the enable flag, the state
// entered by that request (zero when none) and the worst fault-to-recovery
// and alarm-to-recovery times in ticks.
// Config channel (csr_valid / csr_ready): csr_index 0..3 selects alarm,
// fault, recovery timeouts and recovery hold; other indexes are ignored.
// csr_ready is always high; write only while the core is idle.
// A request goes from accept into the request register, then through the
// evaluation logic into the response register. Throughput is one
// transaction per cycle while rsp_stall is low.
// When rsp_stall is high the response holds, the request register fills, and
// req_stall rises only once both registers are occupied.
// Reset (synchronous, active high) empties both registers, loads the
// default timeouts and puts the watchdog in INIT with evaluation enabled.
`default_nettype none

module heartbeat_watchdog_fsm_core
   import hbwd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_op,
   input  wire logic [15:0]              req_beat_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [2:0]                    rsp_wd_state,
   output logic                          rsp_is_enabled,
   output logic [2:0]                    rsp_entered,
   output logic [31:0]                   rsp_worst_fault_recovery,
   output logic [31:0]                   rsp_worst_alarm_recovery,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [15:0]              csr_wdata
);

   cfg_type    cfg;
   item_type   item;
   logic       item_valid;
   logic       advance;
   result_type result;
   result_type rsp_result;

   hbwd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hbwd_in_stage u_in_stage (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_beat_value (req_beat_value),
      .advance        (advance),
      .item_valid     (item_valid),
      .item           (item)
   );

   hbwd_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .advance    (advance),
      .cfg        (cfg),
      .result     (result)
   );

   hbwd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   // unpack the response
   assign rsp_wd_state             = rsp_result.wd_state;
   assign rsp_is_enabled           = rsp_result.is_enabled;
   assign rsp_entered              = rsp_result.entered;
   assign rsp_worst_fault_recovery = rsp_result.worst_fault_recovery;
   assign rsp_worst_alarm_recovery = rsp_result.worst_alarm_recovery;

endmodule

`default_nettype wire

// ----- rtl/hbwd_checker.sv -----
`default_nettype none

module hbwd_checker
   import hbwd_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [2:0]  rsp_wd_state,
   input wire logic        rsp_is_enabled,
   input wire logic [2:0]  rsp_entered,
   input wire logic [31:0] rsp_worst_fault_recovery,
   input wire logic [31:0] rsp_worst_alarm_recovery
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_wd_state) &&
         $stable(rsp_entered) && $stable(rsp_worst_fault_recovery))
      else $error("stalled response changed");

   // a reported entry names the state now held
   a_entered_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entered != ST_INIT |-> rsp_entered == rsp_wd_state)
      else $error("entered state differs from current state");

   // while disabled the watchdog sits in init or normal
   a_disabled_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_enabled |->
         rsp_wd_state == ST_INIT || rsp_wd_state == ST_NORMAL)
      else $error("disabled watchdog outside init or normal");

   // worst-case recovery times never shrink
   a_worst_monotonic: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid) && !$past(reset) |->
         rsp_worst_fault_recovery >= $past(rsp_worst_fault_recovery) &&
         rsp_worst_alarm_recovery >= $past(rsp_worst_alarm_recovery))
      else $error("worst recovery time decreased");

endmodule

bind heartbeat_watchdog_fsm_core hbwd_checker u_hbwd_checker (
   .clock                    (clock),
   .reset                    (reset),
   .rsp_valid                (rsp_valid),
   .rsp_stall                (rsp_stall),
   .rsp_wd_state             (rsp_wd_state),
   .rsp_is_enabled           (rsp_is_enabled),
   .rsp_entered              (rsp_entered),
   .rsp_worst_fault_recovery (rsp_worst_fault_recovery),
   .rsp_worst_alarm_recovery (rsp_worst_alarm_recovery)
);

`default_nettype wire

// ----- dv/hbwd_watchdog_checker.sv -----
`default_nettype none

module hbwd_watchdog_checker
   import hbwd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_stall,
   input  wire logic [1:0]               req_op,
   input  wire logic [15:0]              req_beat_value,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   input  wire logic [2:0]               rsp_wd_state,
   input  wire logic                     rsp_is_enabled,
   input  wire logic [2:0]               rsp_entered,
   input  wire logic [31:0]              rsp_worst_fault_recovery,
   input  wire logic [31:0]              rsp_worst_alarm_recovery,
   input  wire logic                     csr_valid,
   input  wire logic                     csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [15:0]              csr_wdata,
   output int                            mismatch_count,
   output int                            responses_owed,
   output int                            responses_checked
);

   // shadow of the watchdog configuration and state
   cfg_type      wd_cfg;
   logic [31:0]  tick_clock;
   logic [15:0]  stored_beat;
   logic [31:0]  change_at;
   logic [31:0]  prior_change_at;
   logic         change_flag;
   logic [1:0]   change_total;
   logic [31:0]  alarm_at;
   logic [31:0]  fault_at;
   logic [31:0]  recovery_at;
   wd_state_type wd_now;
   logic         watch_enabled;
   logic [31:0]  worst_fault_span;
   logic [31:0]  worst_alarm_span;

   result_type   predicted_status_q[$];

   initial begin
      mismatch_count    = 0;
      responses_owed    = 0;
      responses_checked = 0;
   end

   task automatic restore_defaults();
      wd_cfg.alarm_timeout    = ALARM_TIMEOUT_RESET;
      wd_cfg.fault_timeout    = FAULT_TIMEOUT_RESET;
      wd_cfg.recovery_timeout = RECOVERY_TIMEOUT_RESET;
      wd_cfg.recover_hold     = RECOVER_HOLD_RESET;
      tick_clock       = '0;
      stored_beat      = '0;
      change_at        = '0;
      prior_change_at  = '0;
      change_flag      = 1'b0;
      change_total     = '0;
      alarm_at         = '0;
      fault_at         = '0;
      recovery_at      = '0;
      wd_now           = ST_INIT;
      watch_enabled    = 1'b1;
      worst_fault_span = '0;
      worst_alarm_span = '0;
   endtask

   // state machine step on a tick, returns the state entered (init means none)
   function automatic wd_state_type tick_transition();
      logic [31:0] since;
      logic [31:0] between;
      logic [31:0] in_recovery;
      logic [31:0] span;
      since       = tick_clock - change_at;
      between     = change_at - prior_change_at;
      in_recovery = tick_clock - recovery_at;
      // leaving init only needs a change, enable does not matter
      if (wd_now == ST_INIT) begin
         if (change_flag) begin
            wd_now = ST_NORMAL;
            return ST_NORMAL;
         end
         return ST_INIT;
      end
      if (!watch_enabled)
         return ST_INIT;
      if (wd_now == ST_NORMAL && since >= 32'(wd_cfg.alarm_timeout)) begin
         wd_now   = ST_ALARM;
         alarm_at = tick_clock;
         return ST_ALARM;
      end
      if ((wd_now == ST_ALARM && since >= 32'(wd_cfg.fault_timeout)) ||
          (wd_now == ST_RECOVERY && since >= 32'(wd_cfg.recovery_timeout))) begin
         wd_now   = ST_FAULT;
         fault_at = tick_clock;
         return ST_FAULT;
      end
      // recovery needs fresh and closely spaced changes
      if ((wd_now == ST_FAULT || wd_now == ST_ALARM) &&
          since <= 32'(wd_cfg.alarm_timeout) &&
          between <= 32'(wd_cfg.alarm_timeout) &&
          change_total >= CHANGE_COUNT_MAX) begin
         if (wd_now == ST_FAULT) begin
            span = tick_clock - fault_at;
            if (span > worst_fault_span)
               worst_fault_span = span;
         end else begin
            span = tick_clock - alarm_at;
            if (span > worst_alarm_span)
               worst_alarm_span = span;
         end
         recovery_at = tick_clock;
         wd_now      = ST_RECOVERY;
         return ST_RECOVERY;
      end
      if (wd_now == ST_RECOVERY && in_recovery >= 32'(wd_cfg.recover_hold)) begin
         wd_now = ST_NORMAL;
         return ST_NORMAL;
      end
      return ST_INIT;
   endfunction

   // apply one request to the shadow and build the status it should produce
   task automatic predict_watchdog(input op_type op, input logic [15:0] beat,
                                   output result_type status);
      wd_state_type entered_now;
      entered_now = ST_INIT;
      case (op)
         OP_TICK: begin
            tick_clock  = tick_clock + 32'd1;
            entered_now = tick_transition();
         end
         OP_SAMPLE: begin
            if (beat != stored_beat) begin
               if (change_total < CHANGE_COUNT_MAX)
                  change_total = change_total + 2'd1;
               prior_change_at = change_at;
               change_at       = tick_clock;
               change_flag     = 1'b1;
               stored_beat     = beat;
            end
         end
         OP_DISABLE: begin
            watch_enabled = 1'b0;
            alarm_at      = '0;
            fault_at      = '0;
            recovery_at   = '0;
            if (wd_now != ST_INIT && wd_now != ST_NORMAL) begin
               wd_now      = ST_NORMAL;
               entered_now = ST_NORMAL;
            end
            stored_beat     = '0;
            change_at       = '0;
            prior_change_at = '0;
            change_flag     = 1'b0;
         end
         default: begin
            watch_enabled = 1'b1;
         end
      endcase
      status.wd_state             = wd_now;
      status.is_enabled           = watch_enabled;
      status.entered              = entered_now;
      status.worst_fault_recovery = worst_fault_span;
      status.worst_alarm_recovery = worst_alarm_span;
   endtask

   task automatic report_failure(input string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch: %s", what);
   endtask

   // compare, then take config writes and new requests
   always @(posedge clock) begin
      result_type seen;
      result_type wanted;
      if (reset) begin
         restore_defaults();
         predicted_status_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen.wd_state             = wd_state_type'(rsp_wd_state);
            seen.is_enabled           = rsp_is_enabled;
            seen.entered              = wd_state_type'(rsp_entered);
            seen.worst_fault_recovery = rsp_worst_fault_recovery;
            seen.worst_alarm_recovery = rsp_worst_alarm_recovery;
            if (predicted_status_q.size() == 0) begin
               report_failure($sformatf("response with none outstanding: state %0d en %0b",
                                        seen.wd_state, seen.is_enabled));
            end else begin
               wanted = predicted_status_q.pop_front();
               responses_checked++;
               if (seen.wd_state !== wanted.wd_state ||
                   seen.is_enabled !== wanted.is_enabled ||
                   seen.entered !== wanted.entered ||
                   seen.worst_fault_recovery !== wanted.worst_fault_recovery ||
                   seen.worst_alarm_recovery !== wanted.worst_alarm_recovery)
                  report_failure({
                     $sformatf("response %0d expected st %0d en %0b ent %0d wf %0d wa %0d",
                               responses_checked, wanted.wd_state, wanted.is_enabled,
                               wanted.entered, wanted.worst_fault_recovery,
                               wanted.worst_alarm_recovery),
                     $sformatf(", got st %0d en %0b ent %0d wf %0d wa %0d",
                               rsp_wd_state, rsp_is_enabled, rsp_entered,
                               rsp_worst_fault_recovery, rsp_worst_alarm_recovery)});
            end
         end
         // register writes, unknown indexes are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ALARM_TIMEOUT:    wd_cfg.alarm_timeout    = csr_wdata;
               CSR_FAULT_TIMEOUT:    wd_cfg.fault_timeout    = csr_wdata;
               CSR_RECOVERY_TIMEOUT: wd_cfg.recovery_timeout = csr_wdata;
               CSR_RECOVER_HOLD:     wd_cfg.recover_hold     = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predict_watchdog(op_type'(req_op), req_beat_value, wanted);
            predicted_status_q.push_back(wanted);
         end
      end
      responses_owed = predicted_status_q.size();
   end

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`default_nettype none

module tb_top;
   import hbwd_pkg::*;

   localparam int CycleLimit = 300000;
   localparam int HoldCycles = 60;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [1:0]               req_op;
   logic [15:0]              req_beat_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [2:0]               rsp_wd_state;
   logic                     rsp_is_enabled;
   logic [2:0]               rsp_entered;
   logic [31:0]              rsp_worst_fault_recovery;
   logic [31:0]              rsp_worst_alarm_recovery;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [15:0]              csr_wdata;

   int mismatch_count;
   int responses_owed;
   int responses_checked;

   // stimulus bookkeeping
   int          items_sent     = 0;
   int          settings_count = 0;
   int          cycle_count    = 0;
   bit          no_idle        = 1'b0;
   bit          rsp_hold_req   = 1'b0;
   logic [15:0] beat_cur       = 16'd0;
   logic [15:0] alarm_lim      = ALARM_TIMEOUT_RESET;
   logic [15:0] fault_lim      = FAULT_TIMEOUT_RESET;
   logic [15:0] recov_lim      = RECOVERY_TIMEOUT_RESET;

   heartbeat_watchdog_fsm_core u_dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_op                   (req_op),
      .req_beat_value           (req_beat_value),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_wd_state             (rsp_wd_state),
      .rsp_is_enabled           (rsp_is_enabled),
      .rsp_entered              (rsp_entered),
      .rsp_worst_fault_recovery (rsp_worst_fault_recovery),
      .rsp_worst_alarm_recovery (rsp_worst_alarm_recovery),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_index                (csr_index),
      .csr_wdata                (csr_wdata)
   );

   hbwd_watchdog_checker u_checker (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_op                   (req_op),
      .req_beat_value           (req_beat_value),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_wd_state             (rsp_wd_state),
      .rsp_is_enabled           (rsp_is_enabled),
      .rsp_entered              (rsp_entered),
      .rsp_worst_fault_recovery (rsp_worst_fault_recovery),
      .rsp_worst_alarm_recovery (rsp_worst_alarm_recovery),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_index                (csr_index),
      .csr_wdata                (csr_wdata),
      .mismatch_count           (mismatch_count),
      .responses_owed           (responses_owed),
      .responses_checked        (responses_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // response side: random stalls, quiet stretches and one long hold-off
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(negedge clock);
            rsp_hold_req = 1'b0;
         end else if (no_idle) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 22);
         end
      end
   end

   // one request transaction, with random gaps ahead of it
   task automatic send_item(input op_type op, input logic [15:0] beat);
      @(negedge clock);
      while (!no_idle && $urandom_range(0, 99) < 22) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_beat_value <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // drain everything outstanding before touching registers
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (responses_owed == 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CsrIndexWidth-1:0] idx, input logic [15:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_timeouts(input logic [15:0] a, input logic [15:0] f,
                               input logic [15:0] r, input logic [15:0] h);
      csr_write(CSR_ALARM_TIMEOUT, a);
      csr_write(CSR_FAULT_TIMEOUT, f);
      csr_write(CSR_RECOVERY_TIMEOUT, r);
      csr_write(CSR_RECOVER_HOLD, h);
      // a write to an unmapped index must leave the timeouts alone
      csr_write(CsrIndexWidth'($urandom_range(4, 255)), 16'($urandom));
      alarm_lim = a;
      fault_lim = f;
      recov_lim = r;
      settings_count++;
   endtask

   function automatic int capped(input int v, input int cap);
      return (v > cap) ? cap : v;
   endfunction

   function automatic logic [15:0] next_beat();
      if ($urandom_range(0, 3) == 0)
         beat_cur = 16'($urandom);
      else
         beat_cur = beat_cur + 16'd1;
      return beat_cur;
   endfunction

   // ticks with heartbeat changes spaced inside the alarm window
   task automatic healthy_burst();
      int len;
      int gap;
      int quiet_ticks;
      len         = $urandom_range(4, 30);
      gap         = $urandom_range(0, capped(int'(alarm_lim), 40));
      quiet_ticks = 0;
      repeat (len) begin
         if (quiet_ticks >= gap) begin
            send_item(OP_SAMPLE, next_beat());
            quiet_ticks = 0;
            gap         = $urandom_range(0, capped(int'(alarm_lim), 40));
         end
         send_item(OP_TICK, 16'($urandom));
         quiet_ticks++;
      end
   endtask

   // heartbeat stuck: ticks, now and then a repeated value
   task automatic starve_burst();
      int span;
      span = capped(int'(alarm_lim) + int'(fault_lim) + int'(recov_lim) + 3, 80);
      repeat ($urandom_range(1, span)) begin
         if ($urandom_range(0, 9) == 0)
            send_item(OP_SAMPLE, beat_cur);
         send_item(OP_TICK, 16'($urandom));
      end
   endtask

   task automatic noise_burst();
      repeat ($urandom_range(1, 6))
         send_item(op_type'($urandom_range(0, 3)), 16'($urandom));
   endtask

   // disable, a little traffic while off, then usually enable again
   task automatic toggle_burst();
      send_item(OP_DISABLE, 16'($urandom));
      repeat ($urandom_range(0, 8)) begin
         if ($urandom_range(0, 1) == 0)
            send_item(OP_TICK, 16'($urandom));
         else
            send_item(OP_SAMPLE, next_beat());
      end
      if ($urandom_range(0, 9) != 0)
         send_item(OP_ENABLE, 16'($urandom));
   endtask

   task automatic run_traffic(input int count);
      int target;
      int pick;
      target = items_sent + count;
      send_item(OP_ENABLE, 16'($urandom));
      while (items_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 55)
            healthy_burst();
         else if (pick < 80)
            starve_burst();
         else if (pick < 90)
            noise_burst();
         else
            toggle_burst();
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_op         = OP_TICK;
      req_beat_value = 16'd0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_wdata      = 16'd0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: init exit while disabled, then a full walk with short timeouts
      set_timeouts(16'd2, 16'd3, 16'd3, 16'd1);
      csr_write('1, 16'hFFFF);
      send_item(OP_SAMPLE, 16'h0000);
      send_item(OP_TICK, 16'hFFFF);
      send_item(OP_DISABLE, 16'h0000);
      send_item(OP_SAMPLE, 16'hFFFF);
      send_item(OP_TICK, 16'h0000);
      send_item(OP_TICK, 16'h0000);
      send_item(OP_ENABLE, 16'hFFFF);
      send_item(OP_SAMPLE, 16'h0001);
      send_item(OP_SAMPLE, 16'h0001);
      repeat (3) send_item(OP_TICK, 16'h0000);
      send_item(OP_SAMPLE, 16'h0002);
      repeat (2) send_item(OP_TICK, 16'h0000);
      repeat (6) send_item(OP_TICK, 16'h0000);
      send_item(OP_SAMPLE, 16'h0003);
      send_item(OP_SAMPLE, 16'h0004);
      send_item(OP_TICK, 16'h0000);
      send_item(OP_DISABLE, 16'hFFFF);
      send_item(OP_ENABLE, 16'h0000);
      send_item(OP_ENABLE, 16'h0000);
      run_traffic(150);
      settle();

      // all timeouts at zero
      set_timeouts(16'd0, 16'd0, 16'd0, 16'd0);
      run_traffic(120);
      settle();

      // no gaps on either side
      set_timeouts(16'd5, 16'd8, 16'd6, 16'd4);
      no_idle = 1'b1;
      run_traffic(200);
      settle();
      no_idle = 1'b0;

      // long receiver hold-off while requests keep coming
      set_timeouts(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                   16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)));
      rsp_hold_req = 1'b1;
      run_traffic(250);
      settle();

      // all timeouts at maximum
      set_timeouts(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_traffic(100);
      settle();

      set_timeouts(16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)),
                   16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)));
      run_traffic(250);
      settle();

      set_timeouts(ALARM_TIMEOUT_RESET, FAULT_TIMEOUT_RESET,
                   RECOVERY_TIMEOUT_RESET, RECOVER_HOLD_RESET);
      run_traffic(230);
      settle();

      repeat (5) @(posedge clock);
      $display("covered %0d request transactions over %0d timeout settings",
               items_sent, settings_count);
      $display("%0d responses checked", responses_checked);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
